@@ design/assert_macros.svh @@
// assertion macros used by the quadrilateral area design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define QA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define QA_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/qa_pkg.sv @@
// types, constants and tables of the quadrilateral area block
package qa_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CS_W = 5;
	localparam int SQRT_STEPS = 26;
	localparam int SQ_W = 5;

	localparam logic [15:0] HALF_TURN = 16'd46080;
	localparam logic [15:0] QUARTER_TURN = 16'd23040;
	localparam logic [32:0] DEG_TO_RAD = 33'd4797524517;
	localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
	localparam logic [33:0] ONE_Q30 = 34'd1073741824;
	localparam logic [51:0] SQRT_TOP_BIT = 52'd1 << 50;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
	} qa_sides_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		qa_sides_t sides;
	} qa_cordic_t;

	typedef struct packed {
		logic [51:0] n;
		logic [51:0] res;
		logic bad;
	} qa_sqrt_t;

	// atan(2^-i) in q2.30 radians, truncated
	function automatic logic [31:0] atan_q30(input logic [CS_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd843314856;
			5'd1: r = 32'd497837829;
			5'd2: r = 32'd263043836;
			5'd3: r = 32'd133525158;
			5'd4: r = 32'd67021686;
			5'd5: r = 32'd33543515;
			5'd6: r = 32'd16775850;
			5'd7: r = 32'd8388437;
			5'd8: r = 32'd4194282;
			5'd9: r = 32'd2097149;
			5'd10: r = 32'd1048575;
			5'd11: r = 32'd524287;
			5'd12: r = 32'd262143;
			5'd13: r = 32'd131071;
			5'd14: r = 32'd65535;
			5'd15: r = 32'd32767;
			5'd16: r = 32'd16383;
			5'd17: r = 32'd8191;
			5'd18: r = 32'd4095;
			5'd19: r = 32'd2047;
			5'd20: r = 32'd1023;
			5'd21: r = 32'd511;
			5'd22: r = 32'd255;
			5'd23: r = 32'd127;
			5'd24: r = 32'd63;
			5'd25: r = 32'd31;
			5'd26: r = 32'd15;
			5'd27: r = 32'd7;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/qa_in_if.sv @@
// input channel: four sides and the opposite angle sum
interface qa_in_if;
	logic valid;
	logic ready;
	logic [15:0] side_a;
	logic [15:0] side_b;
	logic [15:0] side_c;
	logic [15:0] side_d;
	logic [15:0] angle_sum_deg;

	modport source (output valid, side_a, side_b, side_c, side_d, angle_sum_deg, input ready);
	modport sink (input valid, side_a, side_b, side_c, side_d, angle_sum_deg, output ready);
endinterface

@@ design/qa_out_if.sv @@
// output channel: area and invalid flag
interface qa_out_if;
	logic valid;
	logic ready;
	logic [23:0] area;
	logic invalid;

	modport source (output valid, area, invalid, input ready);
	modport sink (input valid, area, invalid, output ready);
endinterface

@@ design/qa_cordic_cell.sv @@
// one rotation step of the cosine cordic chain
module qa_cordic_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [qa_pkg::CS_W-1:0] step,
	input logic valid_i,
	input qa_pkg::qa_cordic_t d_i,
	output logic valid_o,
	output qa_pkg::qa_cordic_t d_o
);
	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [33:0] at;
	qa_pkg::qa_cordic_t nxt;

	always_comb begin
		xs = d_i.x >>> step;
		ys = d_i.y >>> step;
		at = signed'({2'b00, qa_pkg::atan_q30(step)});
		nxt = d_i;
		if (d_i.z >= 0) begin
			nxt.x = d_i.x - ys;
			nxt.y = d_i.y + xs;
			nxt.z = d_i.z - at;
		end else begin
			nxt.x = d_i.x + ys;
			nxt.y = d_i.y - xs;
			nxt.z = d_i.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end
endmodule

@@ design/qa_sqrt_cell.sv @@
// one digit of the restoring square root chain
module qa_sqrt_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [qa_pkg::SQ_W-1:0] step,
	input logic valid_i,
	input qa_pkg::qa_sqrt_t d_i,
	output logic valid_o,
	output qa_pkg::qa_sqrt_t d_o
);
	logic [51:0] bit_w;
	logic [52:0] trial;
	qa_pkg::qa_sqrt_t nxt;

	always_comb begin
		bit_w = qa_pkg::SQRT_TOP_BIT >> {step, 1'b0};
		trial = {1'b0, d_i.res} + {1'b0, bit_w};
		nxt = d_i;
		if ({1'b0, d_i.n} >= trial) begin
			nxt.n = d_i.n - trial[51:0];
			nxt.res = (d_i.res >> 1) + bit_w;
		end else begin
			nxt.res = d_i.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end
endmodule

@@ design/quadrilateral_area_from_sides.sv @@
// an accepted word passes stage 1, the cordic cells, stages 2 to 6, the root digit cells and the output register
// throughput: one word per cycle; the whole pipeline advances unless the result stalls
// depth is set by the cordic cells (one per step) and the 26 root digit cells
// reset clears only the stage valid bits; no state is carried between words
`include "assert_macros.svh"
module quadrilateral_area_from_sides (
	input logic clk,
	input logic arst_n,
	qa_in_if.sink sample,
	qa_out_if.source result
);
	logic en;

	// stage 1: angle folding and degrees to radians
	logic [15:0] h1;
	logic [14:0] h2;
	logic [47:0] zprod;
	logic v_s1;
	qa_pkg::qa_sides_t sides_s1;
	logic [31:0] z_s1;

	logic c_v [0:qa_pkg::CORDIC_STEPS];
	qa_pkg::qa_cordic_t c_d [0:qa_pkg::CORDIC_STEPS];

	// stage 2: cos^2, half-perimeter differences, first products
	qa_pkg::qa_cordic_t cl;
	logic [33:0] ax;
	logic [30:0] axc;
	logic [61:0] sq;
	logic [17:0] tsum;
	logic signed [18:0] f [0:3];
	logic [17:0] mag [0:3];
	logic zero_c;
	logic neg_c;
	logic v_s2;
	logic [30:0] cos2_s2;
	logic [35:0] m01_s2;
	logic [35:0] m23_s2;
	logic [31:0] sab_s2;
	logic [31:0] scd_s2;
	logic bad_s2;

	// stage 3..6
	logic v_s3;
	logic [30:0] cos2_s3;
	logic [63:0] abcd_s3;
	logic [53:0] fpl_s3;
	logic [53:0] fph_s3;
	logic bad_s3;
	logic v_s4;
	logic [71:0] first_s4;
	logic [62:0] spl_s4;
	logic [62:0] sph_s4;
	logic bad_s4;
	logic v_s5;
	logic [71:0] first_s5;
	logic [94:0] second_s5;
	logic bad_s5;
	logic [97:0] fw;
	logic [97:0] sw;
	logic [97:0] rad;
	logic v_s6;
	qa_pkg::qa_sqrt_t sq_s6;

	logic q_v [0:qa_pkg::SQRT_STEPS];
	qa_pkg::qa_sqrt_t q_d [0:qa_pkg::SQRT_STEPS];

	logic [25:0] root;
	logic out_v_q;
	logic [23:0] area_q;
	logic inv_q;

	assign en = !out_v_q || result.ready;
	assign sample.ready = en;

	always_comb begin
		h1 = (sample.angle_sum_deg >= qa_pkg::HALF_TURN) ?
			sample.angle_sum_deg - qa_pkg::HALF_TURN : sample.angle_sum_deg;
		h2 = (h1 > qa_pkg::QUARTER_TURN) ? 15'(qa_pkg::HALF_TURN - h1) : h1[14:0];
		zprod = 48'(h2) * 48'(qa_pkg::DEG_TO_RAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sides_s1 <= '{a: sample.side_a, b: sample.side_b,
				c: sample.side_c, d: sample.side_d};
			z_s1 <= zprod[47:16];
		end
	end

	assign c_v[0] = v_s1;
	assign c_d[0] = '{x: qa_pkg::GAIN_INV, y: 34'sd0,
		z: signed'({2'b00, z_s1}), sides: sides_s1};

	for (genvar i = 0; i < qa_pkg::CORDIC_STEPS; i++) begin : g_cordic
		qa_cordic_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.step(qa_pkg::CS_W'(i)),
			.valid_i(c_v[i]),
			.d_i(c_d[i]),
			.valid_o(c_v[i+1]),
			.d_o(c_d[i+1])
		);
	end

	always_comb begin
		cl = c_d[qa_pkg::CORDIC_STEPS];
		ax = (cl.x < 0) ? 34'(-cl.x) : 34'(cl.x);
		axc = (ax > qa_pkg::ONE_Q30) ? 31'(qa_pkg::ONE_Q30) : ax[30:0];
		sq = 62'(axc) * 62'(axc);
		tsum = 18'(cl.sides.a) + 18'(cl.sides.b) + 18'(cl.sides.c) + 18'(cl.sides.d);
		f[0] = signed'({1'b0, tsum}) - signed'({2'b00, cl.sides.a, 1'b0});
		f[1] = signed'({1'b0, tsum}) - signed'({2'b00, cl.sides.b, 1'b0});
		f[2] = signed'({1'b0, tsum}) - signed'({2'b00, cl.sides.c, 1'b0});
		f[3] = signed'({1'b0, tsum}) - signed'({2'b00, cl.sides.d, 1'b0});
		zero_c = 1'b0;
		neg_c = 1'b0;
		for (int k = 0; k < 4; k++) begin
			mag[k] = (f[k] < 0) ? 18'(-f[k]) : 18'(f[k]);
			zero_c = zero_c | (f[k] == 0);
			neg_c = neg_c ^ f[k][18];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s2 <= c_v[qa_pkg::CORDIC_STEPS];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		fw = {first_s5, 26'd0};
		sw = {3'd0, second_s5};
		rad = fw - sw;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos2_s2 <= sq[60:30];
			m01_s2 <= 36'(mag[0]) * 36'(mag[1]);
			m23_s2 <= 36'(mag[2]) * 36'(mag[3]);
			sab_s2 <= 32'(cl.sides.a) * 32'(cl.sides.b);
			scd_s2 <= 32'(cl.sides.c) * 32'(cl.sides.d);
			bad_s2 <= zero_c | neg_c;

			cos2_s3 <= cos2_s2;
			abcd_s3 <= 64'(sab_s2) * 64'(scd_s2);
			fpl_s3 <= 54'(m01_s2) * 54'(m23_s2[17:0]);
			fph_s3 <= 54'(m01_s2) * 54'(m23_s2[35:18]);
			bad_s3 <= bad_s2;

			first_s4 <= 72'(fpl_s3) + {fph_s3, 18'd0};
			spl_s4 <= 63'(abcd_s3[31:0]) * 63'(cos2_s3);
			sph_s4 <= 63'(abcd_s3[63:32]) * 63'(cos2_s3);
			bad_s4 <= bad_s3;

			first_s5 <= first_s4;
			second_s5 <= 95'(spl_s4) + {sph_s4, 32'd0};
			bad_s5 <= bad_s4;

			// radicand truncated to q.16 before the root
			sq_s6.n <= rad[97:46];
			sq_s6.res <= '0;
			sq_s6.bad <= bad_s5 | !(fw > sw);
		end
	end

	assign q_v[0] = v_s6;
	assign q_d[0] = sq_s6;

	for (genvar k = 0; k < qa_pkg::SQRT_STEPS; k++) begin : g_sqrt
		qa_sqrt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.step(qa_pkg::SQ_W'(k)),
			.valid_i(q_v[k]),
			.d_i(q_d[k]),
			.valid_o(q_v[k+1]),
			.d_o(q_d[k+1])
		);
	end

	assign root = q_d[qa_pkg::SQRT_STEPS].res[25:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= q_v[qa_pkg::SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q <= q_d[qa_pkg::SQRT_STEPS].bad;
			if (q_d[qa_pkg::SQRT_STEPS].bad) begin
				area_q <= '0;
			end else if (root > 26'hFFFFFF) begin
				area_q <= 24'hFFFFFF;
			end else begin
				area_q <= root[23:0];
			end
		end
	end

	assign result.valid = out_v_q;
	assign result.area = area_q;
	assign result.invalid = inv_q;

	`QA_ASSERT(a_inv_area_zero, out_v_q && inv_q |-> area_q == 24'd0, "invalid word with nonzero area")
	`QA_ASSERT(a_root_to_out, en && q_v[qa_pkg::SQRT_STEPS] |=> out_v_q, "finished root lost before output")
	`QA_ASSERT(a_degenerate_bad, en && v_s5 && bad_s5 |=> sq_s6.bad, "degenerate sides not flagged")
	`QA_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_v_q, "output valid during reset")
endmodule

@@ tb/quadrilateral_area_from_sides_tb.sv @@
// testbench of the quadrilateral area block: directed and random words checked against a local predictor
module quadrilateral_area_from_sides_tb;

	typedef struct {
		logic [23:0] area;
		logic invalid;
	} area_word_t;

	logic clk = 1'b0;
	logic arst_n;
	int cycles = 0;
	int errors = 0;
	bit no_idle = 1'b0;
	area_word_t area_queue[$];

	qa_in_if in_ch();
	qa_out_if out_ch();

	quadrilateral_area_from_sides dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(in_ch),
		.result(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// atan(2^-i) in q2.30 radians
	localparam longint ATAN_Q30[32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7, 3, 1, 0, 0
	};

	function automatic longint unsigned cos_sq_q30(logic [15:0] ang);
		longint unsigned h;
		longint x, y, z, nx;
		longint unsigned ax;
		h = 64'(ang);
		// cos^2 repeats every half turn, fold into a quarter turn
		if (h >= 46080) h = h - 46080;
		if (h > 23040) h = 46080 - h;
		z = longint'((h * 64'd4797524517) >> 16);
		x = 652032874;
		y = 0;
		for (int i = 0; i < qa_pkg::CORDIC_STEPS && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_Q30[i];
			end
			x = nx;
		end
		ax = (x < 0) ? longint'(-x) : x;
		if (ax > 64'd1073741824) ax = 64'd1073741824;
		return (ax * ax) >> 30;
	endfunction

	function automatic longint unsigned root_of(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic area_word_t predict_area(logic [15:0] sa, logic [15:0] sb,
			logic [15:0] sc, logic [15:0] sd, logic [15:0] ang);
		longint unsigned side[4];
		longint t, f;
		longint unsigned mag[4], abcd, root;
		int negs, zeros;
		logic [127:0] first, second, rad;
		area_word_t r;
		side[0] = 64'(sa);
		side[1] = 64'(sb);
		side[2] = 64'(sc);
		side[3] = 64'(sd);
		t = longint'(side[0]) + longint'(side[1]) + longint'(side[2]) + longint'(side[3]);
		negs = 0;
		zeros = 0;
		for (int k = 0; k < 4; k++) begin
			f = t - 2 * longint'(side[k]);
			if (f < 0) negs++;
			if (f == 0) zeros++;
			mag[k] = (f < 0) ? -f : f;
		end
		first = (128'(mag[0] * mag[1]) * 128'(mag[2] * mag[3])) << 26;
		abcd = (side[0] * side[1]) * (side[2] * side[3]);
		second = 128'(abcd) * 128'(cos_sq_q30(ang));
		if (zeros != 0 || negs % 2 != 0 || !(first > second)) begin
			r.area = '0;
			r.invalid = 1'b1;
		end else begin
			rad = first - second;
			root = root_of(64'(rad >> 46));
			r.area = (root > 64'hFFFFFF) ? 24'hFFFFFF : root[23:0];
			r.invalid = 1'b0;
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 3);
	endfunction

	task automatic send_word(logic [15:0] sa, logic [15:0] sb, logic [15:0] sc,
			logic [15:0] sd, logic [15:0] ang);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.side_a <= sa;
		in_ch.side_b <= sb;
		in_ch.side_c <= sc;
		in_ch.side_d <= sd;
		in_ch.angle_sum_deg <= ang;
		do @(posedge clk); while (!in_ch.ready);
		area_queue.push_back(predict_area(sa, sb, sc, sd, ang));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (area_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_corners();
		send_word(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(16'd256, 16'd256, 16'd256, 16'd256, 16'd23040);
		send_word(16'd256, 16'd256, 16'd256, 16'd256, 16'd0);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd23040);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd46080);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(16'd768, 16'd1024, 16'd768, 16'd1024, 16'd23040);
		send_word(16'd768, 16'd1024, 16'd768, 16'd1024, 16'd40000);
		send_word(16'd1, 16'd1, 16'd1, 16'd1, 16'd23040);
		send_word(16'd1, 16'd2, 16'd2, 16'd2, 16'd11520);
		send_word(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd23040);
		send_word(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd17000);
	endtask

	task automatic test_invalid();
		// one side longer than the other three together
		send_word(16'd256, 16'd256, 16'd256, 16'd2560, 16'd23040);
		// degenerate: one side equals the semiperimeter
		send_word(16'd256, 16'd256, 16'd256, 16'd768, 16'd23040);
		// square with angle sum zero cancels the radicand
		send_word(16'd512, 16'd512, 16'd512, 16'd512, 16'd0);
		send_word(16'd4096, 16'd100, 16'd100, 16'd100, 16'd33000);
	endtask

	task automatic test_random(int count);
		logic [15:0] s[4];
		logic [15:0] ang;
		int base;
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 3))
				0: begin
					for (int k = 0; k < 4; k++) s[k] = 16'($urandom);
				end
				1: begin
					for (int k = 0; k < 4; k++) s[k] = 16'($urandom_range(0, 63));
				end
				default: begin
					// near-regular shapes, mostly real quadrilaterals
					base = $urandom_range(1, 60000);
					for (int k = 0; k < 4; k++)
						s[k] = 16'(base + $urandom_range(0, base / 2 + 1) - base / 4);
				end
			endcase
			ang = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46080));
			send_word(s[0], s[1], s[2], s[3], ang);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		test_random(40);
		wait_drained();
		test_random(40);
	endtask

	// result side: random stalls, compare with the oldest expected word
	initial begin
		int gap;
		area_word_t want;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (area_queue.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = area_queue.pop_front();
				if (out_ch.area !== want.area) begin
					$error("area expected %0d actual %0d", want.area, out_ch.area);
					errors++;
				end
				if (out_ch.invalid !== want.invalid) begin
					$error("invalid expected %0d actual %0d", want.invalid, out_ch.invalid);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.side_a <= '0;
		in_ch.side_b <= '0;
		in_ch.side_c <= '0;
		in_ch.side_d <= '0;
		in_ch.angle_sum_deg <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_invalid();
		test_drain_pause();
		test_random(1500);
		wait_drained();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
